// ===== hw/rtl/byte_entropy_engine_top_defines.svh =====
// assertion helpers for the entropy engine
`ifndef BYTE_ENTROPY_ENGINE_TOP_DEFINES_SVH
`define BYTE_ENTROPY_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BEE_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BEE_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BEE_ASSERT_IMPL(label, clk, rst_n, a, c)
`define BEE_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hw/rtl/bee_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bee_pkg;
    localparam int COUNT_BITS = 27;
    localparam int BINS       = 256;
    localparam int BIN_BITS   = 8;
    localparam int FRAC_BITS  = 24;
    localparam int MANT_BITS  = 30;
    localparam int LG_BITS    = 5 + FRAC_BITS;
    localparam int SUM_BITS   = COUNT_BITS + LG_BITS;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;
    localparam logic [19:0] ENTROPY_MAX = 20'd524288;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [19:0] entropy_q16;
        logic [26:0] byte_total;
        logic        count_overflow;
    } out_item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bee_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ABITS = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [ABITS-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [ABITS-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bee_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "byte_entropy_engine_top_defines.svh"
module bee_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bee_pkg::in_item_t in_item,
    input  wire logic             q_full,
    input  wire logic             unblock,
    output logic                  take,
    output logic                  q_push,
    output bee_pkg::in_item_t     q_data
);
    logic blocked_reg, blocked_next;

    // one item per transfer; after a last byte wait for the back part
    assign take   = !q_full && !blocked_reg;
    assign q_push = start && take;
    assign q_data = in_item;

    // block after a last byte, open again once its result is out
    always_comb
    begin
        blocked_next = blocked_reg;
        if (q_push && in_item.last_byte)
        begin
            blocked_next = 1'b1;
        end
        else if (unblock)
        begin
            blocked_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_reg <= 1'b0;
        end
        else
        begin
            blocked_reg <= blocked_next;
        end
    end

    `BEE_ASSERT_NEXT(a_block_after_last, clk, rst_n, q_push && in_item.last_byte, blocked_reg)
    `BEE_ASSERT_IMPL(a_no_push_full, clk, rst_n, q_full, !q_push)
    `BEE_ASSERT_IMPL(a_no_push_blocked, clk, rst_n, blocked_reg, !q_push)
endmodule
`default_nettype wire

// ===== hw/rtl/bee_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bee_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bee_pkg::in_item_t push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output bee_pkg::in_item_t      head
);
    bee_pkg::in_item_t slot_reg [bee_pkg::QDEPTH];
    logic [bee_pkg::QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [bee_pkg::QPTR_BITS:0]   cnt_reg;

    assign full      = (cnt_reg == (bee_pkg::QPTR_BITS+1)'(bee_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bee_log2.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bee_log2 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [bee_pkg::COUNT_BITS-1:0] x,
    output logic                               done,
    output logic [bee_pkg::LG_BITS-1:0]        lg
);
    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR, L_FIX} lstate_t;
    lstate_t state_reg;
    logic [4:0]  top_reg;
    logic [31:0] m_reg;
    logic [63:0] sq_reg;
    logic [bee_pkg::FRAC_BITS-1:0] frac_reg;
    logic [4:0]  step_reg;
    logic [63:0] sh;

    assign sh = sq_reg >> bee_pkg::MANT_BITS;
    assign lg = {top_reg, frac_reg};

    // normalise one bit a cycle, then square once per fraction bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done      <= 1'b0;
            top_reg   <= '0;
            frac_reg  <= '0;
            step_reg  <= '0;
            m_reg     <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (go)
                    begin
                        top_reg   <= 5'(bee_pkg::COUNT_BITS - 1);
                        m_reg     <= 32'(x) << (bee_pkg::MANT_BITS - bee_pkg::COUNT_BITS + 1);
                        frac_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    if (m_reg[bee_pkg::MANT_BITS] || top_reg == '0)
                    begin
                        sq_reg    <= 64'(m_reg) * 64'(m_reg);
                        state_reg <= L_FIX;
                    end
                    else
                    begin
                        m_reg   <= m_reg << 1;
                        top_reg <= top_reg - 1'b1;
                    end
                end
                L_FIX:
                begin
                    if (sh[bee_pkg::MANT_BITS+1])
                    begin
                        frac_reg <= {frac_reg[bee_pkg::FRAC_BITS-2:0], 1'b1};
                        m_reg    <= 32'(sh >> 1);
                    end
                    else
                    begin
                        frac_reg <= {frac_reg[bee_pkg::FRAC_BITS-2:0], 1'b0};
                        m_reg    <= 32'(sh);
                    end
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= L_SQR;
                end
                L_SQR:
                begin
                    if (step_reg == 5'(bee_pkg::FRAC_BITS))
                    begin
                        done      <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                    else
                    begin
                        sq_reg    <= 64'(m_reg) * 64'(m_reg);
                        state_reg <= L_FIX;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bee_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "byte_entropy_engine_top_defines.svh"
module bee_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire bee_pkg::in_item_t q_head,
    output logic                   q_pop,
    output logic                   res_valid,
    output bee_pkg::out_item_t     res
);
    localparam int CB = bee_pkg::COUNT_BITS;
    localparam int SB = bee_pkg::SUM_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR, S_RUN, S_DRAIN, S_RD, S_RDW, S_LGC, S_LGW, S_MUL,
        S_NEXT, S_LGN, S_LGNW, S_DIV, S_OUT
    } bstate_t;

    bstate_t state_reg;
    logic [7:0]  addr_reg;
    logic [CB-1:0] n_reg;
    logic ovf_reg;
    logic [SB-1:0] sum_reg;
    logic [CB-1:0] c_reg;
    logic [SB-1:0] rem_reg;
    logic [SB-1:0] quo_reg;
    logic [5:0]  dbit_reg;
    logic [bee_pkg::LG_BITS-1:0] ln_reg;
    logic [SB-1:0] prod_reg;

    // histogram write pipeline with forwarding
    logic              p1_v_reg;
    logic [7:0]        p1_a_reg;
    logic              p2_v_reg;
    logic [7:0]        p2_a_reg;
    logic [CB-1:0]     p2_d_reg;

    logic          ram_we;
    logic [7:0]    ram_waddr, ram_raddr;
    logic [CB-1:0] ram_wdata, ram_rdata, cur, incv;
    logic          lg_go, lg_done;
    logic [CB-1:0] lg_x;
    logic [bee_pkg::LG_BITS-1:0] lg_out;
    logic          take;
    logic [SB:0]   trial;
    logic [SB-1:0] hdiff;
    logic [SB-1:0] hq;

    bee_ram #(.WIDTH(CB), .DEPTH(bee_pkg::BINS)) u_hist (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    bee_log2 u_lg (
        .clk(clk), .rst_n(rst_n), .go(lg_go), .x(lg_x), .done(lg_done), .lg(lg_out)
    );

    assign take  = (state_reg == S_RUN) && q_valid;
    assign q_pop = take;
    assign cur   = (p2_v_reg && p2_a_reg == p1_a_reg) ? p2_d_reg : ram_rdata;
    assign incv  = cur + 1'b1;
    assign ram_raddr = (state_reg == S_RUN) ? q_head.data_byte : addr_reg[7:0];
    assign ram_we    = (state_reg == S_CLEAR) || p1_v_reg;
    assign ram_waddr = (state_reg == S_CLEAR) ? addr_reg[7:0] : p1_a_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : incv;
    assign lg_go = (state_reg == S_LGC) || (state_reg == S_LGN);
    assign lg_x  = (state_reg == S_LGN) ? n_reg : c_reg;
    assign trial = {rem_reg, quo_reg[SB-1]} - {1'b0, SB'(n_reg)};
    assign hdiff = SB'(ln_reg) - quo_reg;
    assign hq    = (hdiff + SB'(128)) >> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= 1'b0;
            p2_v_reg  <= p1_v_reg;
            p2_a_reg  <= p1_a_reg;
            p2_d_reg  <= incv;
            p1_v_reg  <= 1'b0;
            unique case (state_reg)
                // clearing pass, one bin a cycle
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg[7:0] == 8'hFF)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                // count one byte per cycle while the queue is not empty
                S_RUN:
                begin
                    if (take)
                    begin
                        if (n_reg != CMAX)
                        begin
                            p1_v_reg <= 1'b1;
                            p1_a_reg <= q_head.data_byte;
                            n_reg    <= n_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (q_head.last_byte)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!p1_v_reg)
                    begin
                        addr_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                // sum c*lg(c) over the bins
                S_RD: state_reg <= S_RDW;
                S_RDW:
                begin
                    c_reg     <= ram_rdata;
                    state_reg <= (ram_rdata == '0) ? S_NEXT : S_LGC;
                end
                S_LGC: state_reg <= S_LGW;
                S_LGW:
                begin
                    if (lg_done)
                    begin
                        prod_reg  <= SB'(c_reg) * SB'(lg_out);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    sum_reg   <= sum_reg + prod_reg;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    addr_reg  <= addr_reg + 1'b1;
                    state_reg <= (addr_reg[7:0] == 8'hFF) ? S_LGN : S_RD;
                end
                S_LGN:
                begin
                    quo_reg   <= sum_reg + SB'(n_reg >> 1);
                    rem_reg   <= '0;
                    dbit_reg  <= '0;
                    state_reg <= S_LGNW;
                end
                S_LGNW:
                begin
                    if (lg_done)
                    begin
                        ln_reg    <= lg_out;
                        state_reg <= S_DIV;
                    end
                end
                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    if (!trial[SB])
                    begin
                        rem_reg <= trial[SB-1:0];
                        quo_reg <= {quo_reg[SB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[SB-2:0], quo_reg[SB-1]};
                        quo_reg <= {quo_reg[SB-2:0], 1'b0};
                    end
                    dbit_reg <= dbit_reg + 1'b1;
                    if (dbit_reg == 6'(SB - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    res_valid <= 1'b1;
                    if (quo_reg >= SB'(ln_reg))
                    begin
                        res.entropy_q16 <= '0;
                    end
                    else if (hq > SB'(bee_pkg::ENTROPY_MAX))
                    begin
                        res.entropy_q16 <= bee_pkg::ENTROPY_MAX;
                    end
                    else
                    begin
                        res.entropy_q16 <= hq[19:0];
                    end
                    res.byte_total     <= 27'(n_reg);
                    res.count_overflow <= ovf_reg;
                    n_reg     <= '0;
                    ovf_reg   <= 1'b0;
                    addr_reg  <= '0;
                    state_reg <= S_CLEAR;
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    `BEE_ASSERT_IMPL(a_pop_only_run, clk, rst_n, q_pop, state_reg == S_RUN)
    `BEE_ASSERT_NEXT(a_out_then_clear, clk, rst_n, state_reg == S_OUT, res_valid && state_reg == S_CLEAR)
    `BEE_ASSERT_IMPL(a_no_write_in_sum, clk, rst_n, state_reg == S_RDW, !ram_we)
endmodule
`default_nettype wire

// ===== hw/rtl/byte_entropy_engine_top.sv =====
// channel | transfer          | fields
// input   | start && !busy    | in_item: data_byte, last_byte
// result  | done (one cycle)  | result: entropy_q16, byte_total, count_overflow
//
// one byte per cycle while counting and the queue is not empty, from the histogram RAM
// read-modify-write. after the last byte: drain the write pipeline, then read each bin,
// and for a used bin take its log and add the product to the sum; then the log of the
// count, the division and the result. after reset and after each result a clearing pass
// over the 256 bins; the queue takes up to four bytes meanwhile. busy is high while the
// queue is full and from a last byte until its result. results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module byte_entropy_engine_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bee_pkg::in_item_t in_item,
    output logic                   busy,
    output logic                   done,
    output bee_pkg::out_item_t     result
);
    logic take, push, full, nempty, pop;
    bee_pkg::in_item_t qd, head;

    assign busy = !take;

    bee_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .q_full(full),
        .unblock(done), .take(take), .q_push(push), .q_data(qd)
    );

    bee_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(qd), .pop(pop),
        .full(full), .not_empty(nempty), .head(head)
    );

    bee_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(nempty), .q_head(head), .q_pop(pop),
        .res_valid(done), .res(result)
    );
endmodule
`default_nettype wire
